// ===== design/bdq_pkg.sv =====
// Shared types and constants for the bounded deque with search.
package bdq_pkg;

   // Sizes
   localparam int DEPTH_DEFAULT = 16;
   localparam int DATA_W        = 32;
   localparam int OP_W          = 3;
   localparam int ST_W          = 2;

   // Request opcodes (codes five to seven are ignored)
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

   // Response status codes
   localparam logic [ST_W-1:0] ST_OK      = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY   = 2'd2;
   localparam logic [ST_W-1:0] ST_NOMATCH = 2'd3;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch the accepted request
      logic exec;      // run push/pop, or set up a search
      logic scan;      // one step of the search walk
      logic load_rsp;  // move the result into the output register
   } bdq_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic search_go; // request is a search over a non-empty store
      logic scan_hit;  // compared entry matches
      logic scan_miss; // last entry compared without a match
      logic rsp_free;  // output register can take a result
   } bdq_stat_type;

endpackage

// ===== design/bdq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bdq_ctrl.sv =====
// Controller state machine: sequences accept, execute, search walk and response load.
module bdq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  bdq_pkg::bdq_stat_type stat,
   output bdq_pkg::bdq_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_SCAN = 4'b0100,
      S_DONE = 4'b1000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.search_go ? S_SCAN : S_DONE;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_hit || stat.scan_miss) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/bdq_datapath.sv =====
// Datapath: ring pointers, entry RAM, search walk and output register.
module bdq_datapath #(
   parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT,
   localparam int AW   = $clog2(DEPTH),
   localparam int CW   = $clog2(DEPTH + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bdq_pkg::bdq_cmd_type        cmd,
   output bdq_pkg::bdq_stat_type       stat,
   input  logic [bdq_pkg::OP_W-1:0]    req_opcode,
   input  logic signed [bdq_pkg::DATA_W-1:0] req_value,
   input  logic                        rsp_tready,
   output logic                        rsp_valid,
   output logic [bdq_pkg::ST_W-1:0]    rsp_status,
   output logic [CW-1:0]               rsp_position,
   output logic [CW-1:0]               rsp_occupancy
);

   localparam int SUM_W = AW + 1;

   // Request latch
   logic [bdq_pkg::OP_W-1:0]          op_ff, op_in;
   logic signed [bdq_pkg::DATA_W-1:0] val_ff, val_in;
   // Ring state
   logic [AW-1:0]                     front_ff, front_in;
   logic [CW-1:0]                     fill_ff, fill_in;
   // Search walk
   logic [CW-1:0]                     idx_ff, idx_in;
   logic [AW-1:0]                     scan_slot_ff, scan_slot_in;
   logic                              cmp_valid_ff, cmp_valid_in;
   logic [CW-1:0]                     cmp_idx_ff, cmp_idx_in;
   // Pending result
   logic [bdq_pkg::ST_W-1:0]          res_status_ff, res_status_in;
   logic [CW-1:0]                     res_pos_ff, res_pos_in;
   // Output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [bdq_pkg::ST_W-1:0]          rsp_status_ff, rsp_status_in;
   logic [CW-1:0]                     rsp_pos_ff, rsp_pos_in;
   logic [CW-1:0]                     rsp_occ_ff, rsp_occ_in;

   // RAM port signals
   logic                              wr_en;
   logic [AW-1:0]                     wr_addr;
   logic                              rd_en;
   logic [bdq_pkg::DATA_W-1:0]        rd_data;

   logic [AW-1:0]                     front_dec;
   logic [AW-1:0]                     front_inc;
   logic [AW-1:0]                     slot_step;
   logic [SUM_W-1:0]                  back_sum;
   logic [AW-1:0]                     back_slot;
   logic                              full;
   logic                              empty;
   logic                              issue;
   logic                              eq;

   bdq_ram #(
      .WIDTH (bdq_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (val_ff),
      .rd_en   (rd_en),
      .rd_addr (scan_slot_ff),
      .rd_data (rd_data)
   );

   // Ring arithmetic
   assign front_dec = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);
   assign front_inc = (front_ff == AW'(DEPTH - 1)) ? '0 : front_ff + AW'(1);
   assign slot_step = (scan_slot_ff == AW'(DEPTH - 1)) ? '0 : scan_slot_ff + AW'(1);
   assign back_sum  = {1'b0, front_ff} + SUM_W'(fill_ff[AW-1:0]);
   assign back_slot = (back_sum >= SUM_W'(DEPTH)) ? AW'(back_sum - SUM_W'(DEPTH))
                                                  : back_sum[AW-1:0];
   assign full      = (fill_ff == CW'(DEPTH));
   assign empty     = (fill_ff == '0);

   // Search compare on the registered RAM output
   assign issue = cmd.scan && (idx_ff != fill_ff);
   assign eq    = ($signed(rd_data) == val_ff);
   assign rd_en = issue;

   assign stat.search_go = (op_ff == bdq_pkg::OP_SEARCH) && !empty;
   assign stat.scan_hit  = cmp_valid_ff && eq;
   assign stat.scan_miss = cmp_valid_ff && !eq && (idx_ff == fill_ff);
   assign stat.rsp_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      op_in         = op_ff;
      val_in        = val_ff;
      front_in      = front_ff;
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      scan_slot_in  = scan_slot_ff;
      cmp_valid_in  = cmp_valid_ff;
      cmp_idx_in    = cmp_idx_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_occ_in    = rsp_occ_ff;
      wr_en         = 1'b0;
      wr_addr       = back_slot;

      // Latch the accepted transaction
      if (cmd.capture) begin
         op_in  = req_opcode;
         val_in = req_value;
      end

      // Execute the operation
      if (cmd.exec) begin
         res_status_in = bdq_pkg::ST_OK;
         res_pos_in    = '0;
         idx_in        = '0;
         scan_slot_in  = front_ff;
         cmp_valid_in  = 1'b0;
         case (op_ff)
            bdq_pkg::OP_PUSH_FRONT: begin
               if (full) begin
                  res_status_in = bdq_pkg::ST_FULL;
               end else begin
                  front_in = front_dec;
                  wr_en    = 1'b1;
                  wr_addr  = front_dec;
                  fill_in  = fill_ff + CW'(1);
               end
            end
            bdq_pkg::OP_PUSH_BACK: begin
               if (full) begin
                  res_status_in = bdq_pkg::ST_FULL;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = back_slot;
                  fill_in = fill_ff + CW'(1);
               end
            end
            bdq_pkg::OP_POP_FRONT: begin
               if (empty) begin
                  res_status_in = bdq_pkg::ST_EMPTY;
               end else begin
                  front_in = front_inc;
                  fill_in  = fill_ff - CW'(1);
               end
            end
            bdq_pkg::OP_POP_BACK: begin
               if (empty) begin
                  res_status_in = bdq_pkg::ST_EMPTY;
               end else begin
                  fill_in = fill_ff - CW'(1);
               end
            end
            bdq_pkg::OP_SEARCH: begin
               res_status_in = empty ? bdq_pkg::ST_EMPTY : bdq_pkg::ST_NOMATCH;
            end
            default: begin
            end
         endcase
      end

      // One entry read and one compare per cycle
      if (cmd.scan) begin
         cmp_valid_in = issue;
         cmp_idx_in   = idx_ff;
         if (issue) begin
            idx_in       = idx_ff + CW'(1);
            scan_slot_in = slot_step;
         end
         if (stat.scan_hit) begin
            res_status_in = bdq_pkg::ST_OK;
            res_pos_in    = cmp_idx_ff + CW'(1);
         end
      end

      // Output register
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_pos_in    = res_pos_ff;
         rsp_occ_in    = fill_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         fill_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         fill_ff      <= fill_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      scan_slot_ff  <= scan_slot_in;
      cmp_idx_ff    <= cmp_idx_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_position  = rsp_pos_ff;
   assign rsp_occupancy = rsp_occ_ff;

   // Occupancy never exceeds the store size
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH))
      else $error("fill count above depth");

   // Front pointer stays inside the ring
   a_front_bound: assert property (@(posedge clock) disable iff (reset)
      front_ff <= AW'(DEPTH - 1))
      else $error("front slot outside ring");

   // A reported position comes only with a successful search
   a_pos_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_pos_ff != '0) |-> rsp_status_ff == bdq_pkg::ST_OK)
      else $error("position reported without match");

   // A match position lies within the occupied range
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_pos_ff <= rsp_occ_ff)
      else $error("position beyond occupancy");

   // The walk never reads past the occupied entries
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      cmp_valid_ff |-> cmp_idx_ff < fill_ff)
      else $error("search read outside occupied range");

endmodule

// ===== design/bounded_deque_with_search.sv =====
// Top level of the bounded deque with search: ports, controller and datapath.
//
// A ring deque of DEPTH signed 32-bit entries. Each request transaction carries
// an opcode (push front, push back, pop front, pop back, search) and a value,
// and produces exactly one response transaction with status, search position
// and occupancy. Requests are handled one at a time. Push, pop and ignored
// opcodes go from acceptance through an execute state to a done state, which
// registers the response once the output register can take it; only then is
// the next request taken. A search walks the entries in a scan state between
// execute and done, stopping at the first match or after the last occupied
// entry. The entry RAM delivers one entry per cycle through its single
// registered read port. A finished response sits in an output register, so
// the next request can be accepted while it waits to be taken.
// Entries have no reset; only occupied slots are ever read.
module bounded_deque_with_search #(
   parameter int DEPTH  = bdq_pkg::DEPTH_DEFAULT,
   localparam int CW    = $clog2(DEPTH + 1),
   localparam int RSP_W = ((bdq_pkg::ST_W + 2 * CW + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   // Request channel
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [bdq_pkg::DATA_W-1:0] req_tdata,  // value
   input  logic [bdq_pkg::OP_W-1:0]  req_tuser,   // opcode
   // Response channel
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_W-1:0]          rsp_tdata    // status, position, occupancy, zero pad
);

   bdq_pkg::bdq_cmd_type  cmd;
   bdq_pkg::bdq_stat_type stat;

   logic [bdq_pkg::ST_W-1:0] rsp_status;
   logic [CW-1:0]            rsp_position;
   logic [CW-1:0]            rsp_occupancy;

   bdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bdq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_opcode    (req_tuser),
      .req_value     ($signed(req_tdata)),
      .rsp_tready    (rsp_tready),
      .rsp_valid     (rsp_tvalid),
      .rsp_status    (rsp_status),
      .rsp_position  (rsp_position),
      .rsp_occupancy (rsp_occupancy)
   );

   // Pack the response, first field in the low bits
   assign rsp_tdata = RSP_W'({rsp_occupancy, rsp_position, rsp_status});

endmodule

// ===== tb/bounded_deque_with_search_tb.sv =====
// Self-checking testbench for the bounded deque with search: directed and random traffic.
module bounded_deque_with_search_tb;

   localparam int DEPTH      = bdq_pkg::DEPTH_DEFAULT;
   localparam int CW         = $clog2(DEPTH + 1);
   localparam int RSP_W      = ((bdq_pkg::ST_W + 2 * CW + 7) / 8) * 8;
   localparam int RAND_ITEMS = 750;
   localparam int STALL_LONG = 300;
   localparam int HOLD_AT    = 300;
   localparam int IDLE_LIMIT = 3000;
   localparam int REPORT_MAX = 10;

   // One decoded response transaction
   typedef struct packed {
      logic [bdq_pkg::ST_W-1:0] status;
      logic [CW-1:0]            position;
      logic [CW-1:0]            occupancy;
   } deque_reply_type;

   // Shadow copy of the deque; queues the reply each request should produce
   class deque_shadow;
      logic [bdq_pkg::DATA_W-1:0] slots [DEPTH];
      int head;
      int used;
      deque_reply_type awaited_replies [$];
      int mismatches;
      int replies_seen;
      int hits, misses, fulls, empties;

      function new();
         head = 0;
         used = 0;
         mismatches = 0;
         replies_seen = 0;
         hits = 0;
         misses = 0;
         fulls = 0;
         empties = 0;
      endfunction

      function int pending();
         return awaited_replies.size();
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $time, msg);
      endfunction

      // Update the shadow for one accepted request and queue its reply
      function void apply_request(logic [bdq_pkg::OP_W-1:0] op,
                                  logic [bdq_pkg::DATA_W-1:0] val);
         deque_reply_type r;
         bit found;
         int k;
         r.status = bdq_pkg::ST_OK;
         r.position = '0;
         found = 1'b0;
         case (op)
            bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
               if (used == DEPTH) begin
                  r.status = bdq_pkg::ST_FULL;
               end else if (op == bdq_pkg::OP_PUSH_FRONT) begin
                  head = (head + DEPTH - 1) % DEPTH;
                  slots[head] = val;
                  used++;
               end else begin
                  slots[(head + used) % DEPTH] = val;
                  used++;
               end
            end
            bdq_pkg::OP_POP_FRONT, bdq_pkg::OP_POP_BACK: begin
               if (used == 0) begin
                  r.status = bdq_pkg::ST_EMPTY;
               end else begin
                  if (op == bdq_pkg::OP_POP_FRONT)
                     head = (head + 1) % DEPTH;
                  used--;
               end
            end
            bdq_pkg::OP_SEARCH: begin
               if (used == 0) begin
                  r.status = bdq_pkg::ST_EMPTY;
               end else begin
                  r.status = bdq_pkg::ST_NOMATCH;
                  // first match counted from the front, 1-based
                  for (k = 0; k < used; k++) begin
                     if (!found && slots[(head + k) % DEPTH] == val) begin
                        found = 1'b1;
                        r.status = bdq_pkg::ST_OK;
                        r.position = CW'(k + 1);
                     end
                  end
               end
            end
            default: begin
               // unused opcodes leave everything as is
            end
         endcase
         r.occupancy = CW'(used);
         case (r.status)
            bdq_pkg::ST_FULL:    fulls++;
            bdq_pkg::ST_EMPTY:   empties++;
            bdq_pkg::ST_NOMATCH: misses++;
            default:             if (found) hits++;
         endcase
         awaited_replies.push_back(r);
      endfunction

      // Compare one accepted response with the oldest queued reply
      function void match_reply(logic [RSP_W-1:0] data);
         deque_reply_type act, exp;
         act.status = data[bdq_pkg::ST_W-1:0];
         act.position = data[bdq_pkg::ST_W +: CW];
         act.occupancy = data[bdq_pkg::ST_W + CW +: CW];
         replies_seen++;
         if (awaited_replies.size() == 0) begin
            flag($sformatf("unexpected response status=%0d position=%0d occupancy=%0d",
                           act.status, act.position, act.occupancy));
         end else begin
            exp = awaited_replies.pop_front();
            if (act.status !== exp.status || act.position !== exp.position ||
                act.occupancy !== exp.occupancy)
               flag($sformatf("expected status=%0d position=%0d occupancy=%0d, got %0d/%0d/%0d",
                              exp.status, exp.position, exp.occupancy,
                              act.status, act.position, act.occupancy));
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [bdq_pkg::DATA_W-1:0] req_tdata = '0;
   logic [bdq_pkg::OP_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   deque_shadow shadow = new();
   int requests_taken = 0;
   bit no_gaps = 1'b0;
   bit hold_done = 1'b0;

   // Values that recur, so searches hit and duplicates appear
   logic [bdq_pkg::DATA_W-1:0] value_pool [8] = '{32'h0000_0000, 32'h0000_0001,
                                                  32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                                  32'h8000_0000, 32'h0000_0005,
                                                  32'h5555_5555, 32'hAAAA_AAAA};

   bounded_deque_with_search dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Idle length: mostly none or short, now and then long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [bdq_pkg::DATA_W-1:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return value_pool[$urandom_range(0, 7)];
      if (r < 65) return bdq_pkg::DATA_W'($urandom_range(0, 15));
      return $urandom;
   endfunction

   // Offer one request transaction and wait until it is taken
   task automatic send_request(input logic [bdq_pkg::OP_W-1:0] op,
                               input logic [bdq_pkg::DATA_W-1:0] val);
      int gap;
      gap = no_gaps ? 0 : idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= val;
      do @(posedge clock); while (!req_tready);
      shadow.apply_request(op, val);
      requests_taken++;
   endtask

   // Random op, weighted toward filling or draining the store
   task automatic send_random(input bit filling);
      int r;
      logic [bdq_pkg::OP_W-1:0] op;
      r = $urandom_range(0, 99);
      if (r < 3)
         op = bdq_pkg::OP_W'($urandom_range(5, 7));
      else if (r < 25)
         op = bdq_pkg::OP_SEARCH;
      else if (r < (filling ? 85 : 40))
         op = ($urandom_range(0, 1) == 0) ? bdq_pkg::OP_PUSH_FRONT : bdq_pkg::OP_PUSH_BACK;
      else
         op = ($urandom_range(0, 1) == 0) ? bdq_pkg::OP_POP_FRONT : bdq_pkg::OP_POP_BACK;
      send_request(op, pick_value());
   endtask

   // Receiver: check accepted responses, then pick the next ready level
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            shadow.match_reply(rsp_tdata);
         if (!reset) begin
            if (!hold_done && requests_taken >= HOLD_AT) begin
               // long hold-off so the block backs up and stalls its input
               hold_done = 1'b1;
               stall_left = STALL_LONG;
            end else if (stall_left == 0 && !no_gaps && $urandom_range(0, 3) == 0) begin
               stall_left = idle_len();
            end
            if (stall_left > 0) begin
               rsp_tready <= 1'b0;
               stall_left--;
            end else begin
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   // Watchdog: too many cycles in a row with no transaction
   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle = 0;
         else
            idle++;
      end
      $display("timeout after %0d idle cycles", IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   // Stimulus and final report
   initial begin
      int k;
      int sent;
      bit filling;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty cases, ignored opcodes, extremes, full and deepest match
      send_request(bdq_pkg::OP_SEARCH, 32'h0000_0001);
      send_request(bdq_pkg::OP_POP_FRONT, 32'h0);
      send_request(bdq_pkg::OP_POP_BACK, 32'hFFFF_FFFF);
      send_request(bdq_pkg::OP_W'(5), 32'h1234_5678);
      send_request(bdq_pkg::OP_W'(7), 32'hFFFF_FFFF);
      send_request(bdq_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF);
      send_request(bdq_pkg::OP_PUSH_BACK, 32'h8000_0000);
      send_request(bdq_pkg::OP_SEARCH, 32'h8000_0000);
      send_request(bdq_pkg::OP_SEARCH, 32'h0);
      for (k = 0; k < DEPTH - 2; k++)
         send_request(bdq_pkg::OP_PUSH_FRONT, bdq_pkg::DATA_W'(100 + k));
      send_request(bdq_pkg::OP_PUSH_FRONT, 32'h0);
      send_request(bdq_pkg::OP_PUSH_BACK, 32'h0);
      send_request(bdq_pkg::OP_SEARCH, 32'h8000_0000);
      send_request(bdq_pkg::OP_SEARCH, 32'h7FFF_FFFF);

      // random: blocks that lean toward filling or draining
      sent = 0;
      filling = 1'b0;
      while (sent < RAND_ITEMS) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         for (k = $urandom_range(20, 50); k > 0 && sent < RAND_ITEMS; k--) begin
            send_random(filling);
            sent++;
         end
         filling = ~filling;
      end
      req_tvalid <= 1'b0;
      no_gaps = 1'b0;

      while (shadow.pending() != 0) @(posedge clock);
      repeat (4 * DEPTH) @(posedge clock);

      $display("%0d requests, %0d responses: %0d search hits, %0d misses,",
               requests_taken, shadow.replies_seen, shadow.hits, shadow.misses);
      $display("%0d pushes refused when full, %0d requests on an empty store",
               shadow.fulls, shadow.empties);
      if (shadow.mismatches == 0 && shadow.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches, %0d responses missing", shadow.mismatches,
                  shadow.pending());
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
